// ----- rtl/core/line_position_steering_control_assert.svh -----
// ----------------------------------------------------------------------------
// line position steering control assertion macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_STEERING_CONTROL_ASSERT_SVH
`define LINE_POSITION_STEERING_CONTROL_ASSERT_SVH

// same-cycle implication
`define LPSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpsc_pkg
// types, widths, register codes and reset values of the steering control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpsc_pkg;

  // sensor bar and normalization
  localparam int SENSOR_COUNT = 8;
  localparam int INPUT_LANES  = 8;
  localparam int NORM_SPAN    = 1000;

  // field widths
  localparam int SAMPLE_W  = 10;
  localparam int FLOOR_W   = 11;
  localparam int DUTY_W    = 8;
  localparam int GAIN_W    = 16;
  localparam int POS_W     = 12;
  localparam int POS_FRAC  = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // derived widths
  localparam int CNT_W   = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int WT_W    = $clog2(SENSOR_COUNT + 1);
  localparam int NORM_W  = $clog2(NORM_SPAN + 1);
  localparam int DEN_MAX = NORM_SPAN * SENSOR_COUNT;
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int NUM_MAX = NORM_SPAN * SENSOR_COUNT * (SENSOR_COUNT + 1) / 2;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int POS_MAX = SENSOR_COUNT * (1 << POS_FRAC);

  // shared divider: quotient bits, divisor and dividend widths, bits per step, iterations
  localparam int DIV_QW    = POS_W;
  localparam int DIV_DW    = (DEN_W > SAMPLE_W) ? DEN_W : SAMPLE_W;
  localparam int DIV_NW_A  = SAMPLE_W + NORM_W;
  localparam int DIV_NW_B  = NUM_W + POS_FRAC;
  localparam int DIV_NW    = (DIV_NW_A > DIV_NW_B) ? DIV_NW_A : DIV_NW_B;
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITER  = DIV_QW / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITER);

  // steering arithmetic
  localparam int DRV_W   = GAIN_W + 1 + POS_W + 1;
  localparam int SUM_W   = DRV_W + 2;
  localparam int Q16     = 16;
  localparam int WHEEL_W = SUM_W - Q16;

  // reset values
  localparam logic [DUTY_W-1:0]  PWM_MIN_RESET    = 8'd25;
  localparam logic [DUTY_W-1:0]  PWM_MAX_RESET    = 8'd50;
  localparam logic [DUTY_W-1:0]  BASE_DUTY_RESET  = 8'd40;
  localparam logic [DUTY_W-1:0]  LEFT_CORR_RESET  = 8'd15;
  localparam logic [GAIN_W-1:0]  GAIN_KP_RESET    = 16'd3072;
  localparam logic [POS_W-1:0]   TARGET_POS_RESET = 12'd1152;
  localparam logic [POS_W-1:0]   ACC_LOW_RESET    = 12'd256;
  localparam logic [POS_W-1:0]   ACC_HIGH_RESET   = 12'd1280;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET      = 11'd1024;

  // operation codes
  typedef enum logic {
    OP_CAL = 1'b0,
    OP_RUN = 1'b1
  } op_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PWM_MIN     = 3'd0,
    REG_PWM_MAX     = 3'd1,
    REG_BASE_DUTY   = 3'd2,
    REG_LEFT_CORR   = 3'd3,
    REG_GAIN_KP     = 3'd4,
    REG_TARGET_POS  = 3'd5,
    REG_ACCEPT_LOW  = 3'd6,
    REG_ACCEPT_HIGH = 3'd7
  } cfg_index_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL,
    S_NORM_LOAD,
    S_NORM_DIV,
    S_NORM_ACC,
    S_CENT_LOAD,
    S_CENT_DIV,
    S_CENT_CHECK,
    S_STEER_MUL,
    S_STEER_ADD,
    S_DONE
  } state_t;

  // input beat
  typedef struct packed {
    op_t                 op;
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
    logic [POS_W-1:0]    line_position;
    logic                position_held;
    logic [FLOOR_W-1:0]  range_floor;
    logic [SAMPLE_W-1:0] range_ceiling;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- rtl/core/lpsc_in_if.sv -----
// ----------------------------------------------------------------------------
// lpsc_in_if
// valid/ready channel carrying one sensor frame per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpsc_in_if;
  import lpsc_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lpsc_out_if.sv -----
// ----------------------------------------------------------------------------
// lpsc_out_if
// valid/ready channel carrying one steering result per beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpsc_out_if;
  import lpsc_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/line_position_steering_control.sv -----
// run frame: per sensor a load, a division and an accumulate, then the
// centroid division, window check, steering multiply and add; no new frame
// is taken until the result is loaded; the shared divider retires 2 quotient
// bits a cycle (9 divisions); degenerate range: division is skipped
// calibrate frame: one sample per cycle, then the result is loaded
// reset (rst, synchronous): registers to their defaults, range to empty
// ----------------------------------------------------------------------------
// line_position_steering_control
// weighted-centroid line position and proportional wheel steering
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_position_steering_control (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lpsc_in_if.sink                               frame,
  lpsc_out_if.source                            result,
  input  wire logic                             cfg_we,
  input  wire lpsc_pkg::cfg_index_t             cfg_index,
  input  wire logic [lpsc_pkg::CFG_W-1:0]       cfg_data
);
  import lpsc_pkg::*;

  // configuration registers
  logic [DUTY_W-1:0] pwm_min;
  logic [DUTY_W-1:0] pwm_max;
  logic [DUTY_W-1:0] base_duty;
  logic [DUTY_W-1:0] left_correction;
  logic [GAIN_W-1:0] gain_kp;
  logic [POS_W-1:0]  target_pos;
  logic [POS_W-1:0]  accept_low;
  logic [POS_W-1:0]  accept_high;

  // persistent state
  logic [FLOOR_W-1:0]  cal_floor;
  logic [SAMPLE_W-1:0] cal_ceiling;
  logic [POS_W-1:0]    last_position;

  // sequencer
  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic               frame_ready;
  logic               div_run;
  logic               done_load;
  logic               cnt_last;
  logic               div_last;

  // item registers
  logic [SAMPLE_W-1:0] samp [SENSOR_COUNT];
  logic [SAMPLE_W-1:0] frame_samp [INPUT_LANES];
  logic                is_run;
  logic [NUM_W-1:0]    num_acc;
  logic [DEN_W-1:0]    den_acc;
  logic [POS_W-1:0]    pos_r;
  logic                held_r;
  logic signed [DRV_W-1:0]   drive;
  logic signed [WHEEL_W-1:0] left_w;
  logic signed [WHEEL_W-1:0] right_w;

  // shared divider registers
  logic [DIV_DW-1:0] div_rem;
  logic [DIV_QW-1:0] div_sh;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_DW-1:0] step_rem;
  logic [DIV_QW-1:0] step_sh;

  // combinational datapath
  logic [SAMPLE_W-1:0] cur_samp;
  logic                degenerate;
  logic [SAMPLE_W-1:0] clamped;
  logic [SAMPLE_W-1:0] diff;
  logic [DIV_NW-1:0]   norm_dividend;
  logic [DIV_NW-1:0]   cent_dividend;
  logic [WT_W-1:0]     weight;
  logic                reject;
  logic [POS_W-1:0]    pos_sel;
  logic signed [POS_W:0]     err;
  logic signed [SUM_W-1:0]   base_q;
  logic signed [SUM_W-1:0]   drive_x;
  logic [DUTY_W-1:0]   left_clamp;
  logic [DUTY_W-1:0]   right_clamp;
  logic [DUTY_W:0]     left_sum;
  logic [DUTY_W-1:0]   left_sat;

  // truncate a Q16 value toward zero
  function automatic logic signed [WHEEL_W-1:0] trunc_q16(
    input logic signed [SUM_W-1:0] x
  );
    logic signed [SUM_W-1:0] b;
    b = x + (x[SUM_W-1] ? $signed(SUM_W'((1 << Q16) - 1)) : $signed(SUM_W'(0)));
    return WHEEL_W'(b >>> Q16);
  endfunction

  // clamp a wheel to the duty limits, max test last
  function automatic logic [DUTY_W-1:0] wheel_clamp(
    input logic signed [WHEEL_W-1:0] w,
    input logic [DUTY_W-1:0]         lo,
    input logic [DUTY_W-1:0]         hi
  );
    logic signed [WHEEL_W-1:0] v;
    v = w;
    if (v <= $signed(WHEEL_W'(lo))) begin
      v = $signed(WHEEL_W'(lo));
    end
    if (v >= $signed(WHEEL_W'(hi))) begin
      v = $signed(WHEEL_W'(hi));
    end
    return DUTY_W'(v);
  endfunction

  // frame samples as an indexed row
  assign frame_samp[0] = frame.data.sample_0;
  assign frame_samp[1] = frame.data.sample_1;
  assign frame_samp[2] = frame.data.sample_2;
  assign frame_samp[3] = frame.data.sample_3;
  assign frame_samp[4] = frame.data.sample_4;
  assign frame_samp[5] = frame.data.sample_5;
  assign frame_samp[6] = frame.data.sample_6;
  assign frame_samp[7] = frame.data.sample_7;

  assign cur_samp = samp[cnt];
  assign cnt_last = (cnt == CNT_W'(SENSOR_COUNT - 1));
  assign div_last = (div_cnt == DIV_CNT_W'(DIV_ITER - 1));

  // clamp and scale of the current sample
  always_comb begin
    degenerate = ({1'b0, cal_ceiling} <= cal_floor);
    if (cur_samp >= cal_ceiling) begin
      clamped = cal_ceiling;
    end else if ({1'b0, cur_samp} <= cal_floor) begin
      clamped = cal_floor[SAMPLE_W-1:0];
    end else begin
      clamped = cur_samp;
    end
    diff          = clamped - cal_floor[SAMPLE_W-1:0];
    norm_dividend = DIV_NW'(diff) * DIV_NW'(NORM_SPAN);
    cent_dividend = DIV_NW'({num_acc, {POS_FRAC{1'b0}}});
    weight        = WT_W'(cnt) + WT_W'(1);
  end

  // restoring divider, two quotient bits per cycle
  always_comb begin
    logic [DIV_DW:0] trial;
    logic            ge;
    step_rem = div_rem;
    step_sh  = div_sh;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {step_rem, step_sh[DIV_QW-1]};
      ge    = (trial >= {1'b0, div_den});
      if (ge) begin
        step_rem = DIV_DW'(trial - {1'b0, div_den});
      end else begin
        step_rem = DIV_DW'(trial);
      end
      step_sh = {step_sh[DIV_QW-2:0], ge};
    end
  end

  // acceptance window
  always_comb begin
    reject  = (div_sh <= accept_low) || (div_sh > accept_high);
    pos_sel = reject ? last_position : div_sh;
  end

  // steering terms
  always_comb begin
    err     = $signed({1'b0, pos_r}) - $signed({1'b0, target_pos});
    base_q  = $signed(SUM_W'({base_duty, {Q16{1'b0}}}));
    drive_x = SUM_W'(drive);
  end

  // wheel clamp and left correction
  always_comb begin
    left_clamp  = wheel_clamp(left_w, pwm_min, pwm_max);
    right_clamp = wheel_clamp(right_w, pwm_min, pwm_max);
    left_sum    = {1'b0, left_clamp} + {1'b0, left_correction};
    left_sat    = left_sum[DUTY_W] ? {DUTY_W{1'b1}} : left_sum[DUTY_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (frame.valid) begin
          state_next = (frame.data.op == OP_CAL) ? S_CAL : S_NORM_LOAD;
        end
      end
      S_CAL: begin
        if (cnt_last) begin
          state_next = S_DONE;
        end
      end
      S_NORM_LOAD: state_next = degenerate ? S_NORM_ACC : S_NORM_DIV;
      S_NORM_DIV: begin
        if (div_last) begin
          state_next = S_NORM_ACC;
        end
      end
      S_NORM_ACC:  state_next = cnt_last ? S_CENT_LOAD : S_NORM_LOAD;
      S_CENT_LOAD: state_next = (den_acc == '0) ? S_CENT_CHECK : S_CENT_DIV;
      S_CENT_DIV: begin
        if (div_last) begin
          state_next = S_CENT_CHECK;
        end
      end
      S_CENT_CHECK: state_next = S_STEER_MUL;
      S_STEER_MUL:  state_next = S_STEER_ADD;
      S_STEER_ADD:  state_next = S_DONE;
      S_DONE: begin
        if (done_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    frame_ready = 1'b0;
    div_run     = 1'b0;
    done_load   = 1'b0;
    case (state)
      S_IDLE:     frame_ready = 1'b1;
      S_NORM_DIV: div_run = 1'b1;
      S_CENT_DIV: div_run = 1'b1;
      S_DONE:     done_load = !result.valid || result.ready;
      default: begin
        frame_ready = 1'b0;
      end
    endcase
  end

  assign frame.ready = frame_ready;

  // control state, configuration and calibration
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      cnt             <= '0;
      div_cnt         <= '0;
      result.valid    <= 1'b0;
      pwm_min         <= PWM_MIN_RESET;
      pwm_max         <= PWM_MAX_RESET;
      base_duty       <= BASE_DUTY_RESET;
      left_correction <= LEFT_CORR_RESET;
      gain_kp         <= GAIN_KP_RESET;
      target_pos      <= TARGET_POS_RESET;
      accept_low      <= ACC_LOW_RESET;
      accept_high     <= ACC_HIGH_RESET;
      cal_floor       <= FLOOR_RESET;
      cal_ceiling     <= '0;
      last_position   <= '0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_PWM_MIN:     pwm_min <= cfg_data[DUTY_W-1:0];
          REG_PWM_MAX:     pwm_max <= cfg_data[DUTY_W-1:0];
          REG_BASE_DUTY:   base_duty <= cfg_data[DUTY_W-1:0];
          REG_LEFT_CORR:   left_correction <= cfg_data[DUTY_W-1:0];
          REG_GAIN_KP:     gain_kp <= cfg_data[GAIN_W-1:0];
          REG_TARGET_POS:  target_pos <= cfg_data[POS_W-1:0];
          REG_ACCEPT_LOW:  accept_low <= cfg_data[POS_W-1:0];
          REG_ACCEPT_HIGH: accept_high <= cfg_data[POS_W-1:0];
          default: begin
            pwm_min <= pwm_min;
          end
        endcase
      end

      // sample counter
      if (frame_ready && frame.valid) begin
        cnt <= '0;
      end else if (state == S_CAL || state == S_NORM_ACC) begin
        cnt <= cnt + CNT_W'(1);
      end

      // divider iteration counter
      if (div_run) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end else begin
        div_cnt <= '0;
      end

      // range update, one sample a cycle
      if (state == S_CAL) begin
        if (cur_samp >= cal_ceiling) begin
          cal_ceiling <= cur_samp;
        end else if ({1'b0, cur_samp} <= cal_floor) begin
          cal_floor <= {1'b0, cur_samp};
        end
      end

      if (state == S_CENT_CHECK) begin
        last_position <= pos_sel;
      end

      // result register
      if (done_load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (frame.valid) begin
          for (int k = 0; k < SENSOR_COUNT; k++) begin
            samp[k] <= frame_samp[k];
          end
          is_run  <= (frame.data.op == OP_RUN);
          num_acc <= '0;
          den_acc <= '0;
        end
      end
      S_NORM_LOAD: begin
        div_den <= DIV_DW'(cal_ceiling - cal_floor[SAMPLE_W-1:0]);
        if (degenerate) begin
          div_rem <= '0;
          div_sh  <= '0;
        end else begin
          div_rem <= DIV_DW'(norm_dividend >> DIV_QW);
          div_sh  <= norm_dividend[DIV_QW-1:0];
        end
      end
      S_NORM_DIV, S_CENT_DIV: begin
        div_rem <= step_rem;
        div_sh  <= step_sh;
      end
      S_NORM_ACC: begin
        num_acc <= num_acc + NUM_W'(div_sh) * NUM_W'(weight);
        den_acc <= den_acc + DEN_W'(div_sh);
      end
      S_CENT_LOAD: begin
        div_den <= DIV_DW'(den_acc);
        if (den_acc == '0) begin
          div_rem <= '0;
          div_sh  <= '0;
        end else begin
          div_rem <= DIV_DW'(cent_dividend >> DIV_QW);
          div_sh  <= cent_dividend[DIV_QW-1:0];
        end
      end
      S_CENT_CHECK: begin
        pos_r  <= pos_sel;
        held_r <= reject;
      end
      S_STEER_MUL: begin
        drive <= $signed(DRV_W'(gain_kp)) * DRV_W'(err);
      end
      S_STEER_ADD: begin
        left_w  <= trunc_q16(base_q + drive_x);
        right_w <= trunc_q16(base_q - drive_x);
      end
      S_DONE: begin
        if (done_load) begin
          result.data.left_duty     <= is_run ? left_sat : '0;
          result.data.right_duty    <= is_run ? right_clamp : '0;
          result.data.line_position <= is_run ? pos_r : last_position;
          result.data.position_held <= is_run && held_r;
          result.data.range_floor   <= cal_floor;
          result.data.range_ceiling <= cal_ceiling;
        end
      end
      default: begin
        is_run <= is_run;
      end
    endcase
  end

  // checks
  `include "line_position_steering_control_assert.svh"

  `LPSC_ASSERT_NEXT(a_ceiling_grows, 1'b1, cal_ceiling >= $past(cal_ceiling), "range ceiling fell")
  `LPSC_ASSERT_NEXT(a_floor_shrinks, 1'b1, cal_floor <= $past(cal_floor), "range floor rose")
  `LPSC_ASSERT_IMP(a_centroid_bound, state == S_CENT_CHECK, div_sh <= DIV_QW'(POS_MAX), "centroid out of bar")

endmodule

`default_nettype wire

// ----- test/line_position_steering_control_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line position steering control testbench
// drives sensor frames with bursty valid and checks every result beat
// against an in-bench model of the calibration range, the centroid, the
// acceptance window and the wheel duty math, over several register settings
// ----------------------------------------------------------------------------

module tb;
  import lpsc_pkg::*;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_MOSTLY
  } ready_pattern_t;

  logic clk;
  logic rst = 1'b1;

  // stimulus side
  logic                 frame_valid = 1'b0;
  in_beat_t             frame_data  = '0;
  logic                 result_ready = 1'b0;
  logic                 cfg_we    = 1'b0;
  cfg_index_t           cfg_index = REG_PWM_MIN;
  logic [CFG_W-1:0]     cfg_data  = '0;

  lpsc_in_if  frame_bus ();
  lpsc_out_if result_bus ();

  assign frame_bus.valid  = frame_valid;
  assign frame_bus.data   = frame_data;
  assign result_bus.ready = result_ready;

  line_position_steering_control i_dut (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [DUTY_W-1:0]  cfg_pwm_min    = PWM_MIN_RESET;
  logic [DUTY_W-1:0]  cfg_pwm_max    = PWM_MAX_RESET;
  logic [DUTY_W-1:0]  cfg_base_duty  = BASE_DUTY_RESET;
  logic [DUTY_W-1:0]  cfg_left_corr  = LEFT_CORR_RESET;
  logic [GAIN_W-1:0]  cfg_gain_kp    = GAIN_KP_RESET;
  logic [POS_W-1:0]   cfg_target_pos = TARGET_POS_RESET;
  logic [POS_W-1:0]   cfg_acc_low    = ACC_LOW_RESET;
  logic [POS_W-1:0]   cfg_acc_high   = ACC_HIGH_RESET;

  // calibration range and last accepted position
  logic [FLOOR_W-1:0]  range_lo      = FLOOR_RESET;
  logic [SAMPLE_W-1:0] range_hi      = '0;
  logic [POS_W-1:0]    held_position = '0;

  in_beat_t  pending_frames[$];
  out_beat_t expected_results[$];
  int        frames_issued  = 0;
  int        results_seen   = 0;
  int        mismatch_count = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // wheel duty clamp, max test last so inverted limits give pwm_max
  function automatic longint clamp_wheel(input longint v);
    if (v <= longint'(cfg_pwm_min)) v = longint'(cfg_pwm_min);
    if (v >= longint'(cfg_pwm_max)) v = longint'(cfg_pwm_max);
    return v;
  endfunction

  // one frame through the steering model, updating range and position
  function automatic out_beat_t steer_step(input in_beat_t f);
    logic [7:0][SAMPLE_W-1:0] s;
    out_beat_t r;
    int lo, hi, v, n, num, den, pos;
    longint err, drive, lw, rw, ld;
    s = {f.sample_7, f.sample_6, f.sample_5, f.sample_4,
         f.sample_3, f.sample_2, f.sample_1, f.sample_0};
    r = '0;
    if (f.op == OP_CAL) begin
      // widen the shared range, one sample at a time in order
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        if (s[k] >= range_hi) range_hi = s[k];
        else if (s[k] <= range_lo) range_lo = {1'b0, s[k]};
      end
      r.line_position = held_position;
    end else begin
      // normalize and accumulate the centroid
      lo = int'(range_lo);
      hi = int'(range_hi);
      num = 0;
      den = 0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        n = 0;
        if (hi > lo) begin
          v = int'(s[k]);
          if (v >= hi) v = hi;
          else if (v <= lo) v = lo;
          n = (v - lo) * NORM_SPAN / (hi - lo);
        end
        num += n * (k + 1);
        den += n;
      end
      pos = (den == 0) ? 0 : (num * 256) / den;
      pos = pos % 4096;
      // acceptance window, else reuse the previous position
      if (pos <= int'(cfg_acc_low) || pos > int'(cfg_acc_high)) begin
        pos = int'(held_position);
        r.position_held = 1'b1;
      end
      held_position = pos[POS_W-1:0];
      // proportional steering, truncated toward zero
      err   = longint'(pos) - longint'(cfg_target_pos);
      drive = longint'(cfg_gain_kp) * err;
      lw = (longint'(cfg_base_duty) * 65536 + drive) / 65536;
      rw = (longint'(cfg_base_duty) * 65536 - drive) / 65536;
      ld = clamp_wheel(lw) + longint'(cfg_left_corr);
      if (ld > 255) ld = 255;
      r.left_duty     = ld[7:0];
      r.right_duty    = DUTY_W'(clamp_wheel(rw));
      r.line_position = pos[POS_W-1:0];
    end
    r.range_floor   = range_lo;
    r.range_ceiling = range_hi;
    return r;
  endfunction

  // frame builders
  function automatic in_beat_t pack_frame(input op_t op, input logic [7:0][SAMPLE_W-1:0] s);
    in_beat_t f;
    f.op       = op;
    f.sample_0 = s[0];
    f.sample_1 = s[1];
    f.sample_2 = s[2];
    f.sample_3 = s[3];
    f.sample_4 = s[4];
    f.sample_5 = s[5];
    f.sample_6 = s[6];
    f.sample_7 = s[7];
    return f;
  endfunction

  function automatic in_beat_t hot_frame(input logic [7:0] mask, input int level);
    logic [7:0][SAMPLE_W-1:0] s;
    for (int k = 0; k < SENSOR_COUNT; k++) s[k] = mask[k] ? SAMPLE_W'(level) : '0;
    return pack_frame(OP_RUN, s);
  endfunction

  // random frame: mostly run frames (line profiles, noise, hot masks), some calibration within a band
  function automatic in_beat_t random_frame(input int band_lo, input int band_hi);
    logic [7:0][SAMPLE_W-1:0] s;
    int kind, center, peak, slope, v;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        s[k] = SAMPLE_W'($urandom_range(band_lo, band_hi));
      end
      return pack_frame(OP_CAL, s);
    end
    if (kind < 62) begin
      // bright bump around a line somewhere under the bar
      center = $urandom_range(0, 112);
      peak   = $urandom_range(300, 1023);
      slope  = $urandom_range(2, 14);
      for (int k = 0; k < SENSOR_COUNT; k++) begin
        v = k * 16 - center;
        if (v < 0) v = -v;
        v = peak - v * slope + $urandom_range(0, 60) - 30;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        s[k] = SAMPLE_W'(v);
      end
      return pack_frame(OP_RUN, s);
    end
    if (kind < 90) begin
      for (int k = 0; k < SENSOR_COUNT; k++) s[k] = SAMPLE_W'($urandom_range(0, 1023));
      return pack_frame(OP_RUN, s);
    end
    return hot_frame(8'($urandom_range(0, 255)),
                     $urandom_range(0, 1) ? 1023 : $urandom_range(0, 1023));
  endfunction

  task automatic queue_frame(input in_beat_t f);
    pending_frames.push_back(f);
    frames_issued++;
  endtask

  task automatic wait_drained();
    while (results_seen != frames_issued) @(posedge clk);
  endtask

  // register write, model copy follows since the block is idle
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_PWM_MIN:     cfg_pwm_min    = val[DUTY_W-1:0];
      REG_PWM_MAX:     cfg_pwm_max    = val[DUTY_W-1:0];
      REG_BASE_DUTY:   cfg_base_duty  = val[DUTY_W-1:0];
      REG_LEFT_CORR:   cfg_left_corr  = val[DUTY_W-1:0];
      REG_GAIN_KP:     cfg_gain_kp    = val[GAIN_W-1:0];
      REG_TARGET_POS:  cfg_target_pos = val[POS_W-1:0];
      REG_ACCEPT_LOW:  cfg_acc_low    = val[POS_W-1:0];
      REG_ACCEPT_HIGH: cfg_acc_high   = val[POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int mn, input int mx, input int base, input int corr,
                               input int kp, input int sp, input int lo, input int hi);
    write_reg(REG_PWM_MIN, CFG_W'(mn));
    write_reg(REG_PWM_MAX, CFG_W'(mx));
    write_reg(REG_BASE_DUTY, CFG_W'(base));
    write_reg(REG_LEFT_CORR, CFG_W'(corr));
    write_reg(REG_GAIN_KP, CFG_W'(kp));
    write_reg(REG_TARGET_POS, CFG_W'(sp));
    write_reg(REG_ACCEPT_LOW, CFG_W'(lo));
    write_reg(REG_ACCEPT_HIGH, CFG_W'(hi));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts of random length with random gaps
  int       burst_left;
  int       gap_left;
  logic     next_valid;
  in_beat_t next_frame;

  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      next_valid = frame_valid;
      next_frame = frame_data;
      if (frame_valid && frame_bus.ready) begin
        expected_results.push_back(steer_step(frame_data));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_frames.size() > 0) begin
          next_frame = pending_frames.pop_front();
          next_valid = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
      frame_valid <= next_valid;
      frame_data  <= next_frame;
    end
  end

  function automatic int field_mismatch(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // receiver: checks each result beat, stalls on its own pattern
  ready_pattern_t ready_pattern;
  int             segment_left = 0;
  int             hold_left    = 0;
  bit             hold_done    = 1'b0;
  int             tick         = 0;
  logic           next_ready;
  out_beat_t      want;
  out_beat_t      got;
  int             bad;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_ready) begin
        got = result_bus.data;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no frame pending");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          bad = field_mismatch("left_duty", 16'(want.left_duty), 16'(got.left_duty))
              + field_mismatch("right_duty", 16'(want.right_duty), 16'(got.right_duty))
              + field_mismatch("line_position", 16'(want.line_position),
                               16'(got.line_position))
              + field_mismatch("position_held", 16'(want.position_held),
                               16'(got.position_held))
              + field_mismatch("range_floor", 16'(want.range_floor), 16'(got.range_floor))
              + field_mismatch("range_ceiling", 16'(want.range_ceiling),
                               16'(got.range_ceiling));
          if (bad != 0) mismatch_count++;
        end
      end
      // one long hold-off mid-run so the block backs up its input
      if (!hold_done && results_seen >= 400) begin
        hold_left = 600;
        hold_done = 1'b1;
      end
      if (segment_left == 0) begin
        ready_pattern = ready_pattern_t'($urandom_range(0, 3));
        segment_left  = $urandom_range(20, 300);
      end
      segment_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (ready_pattern)
          READY_ALWAYS:   next_ready = 1'b1;
          READY_COIN:     next_ready = 1'($urandom_range(0, 1));
          READY_PERIODIC: next_ready = (tick % 4) == 0;
          default:        next_ready = $urandom_range(0, 7) != 0;
        endcase
      end
      result_ready <= next_ready;
    end
  end

  // stimulus sequence
  initial begin
    logic [7:0][SAMPLE_W-1:0] s;
    int band_lo, band_hi, mn;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    apply_setting(int'(PWM_MIN_RESET), int'(PWM_MAX_RESET), int'(BASE_DUTY_RESET),
                  int'(LEFT_CORR_RESET), int'(GAIN_KP_RESET), int'(TARGET_POS_RESET),
                  int'(ACC_LOW_RESET), int'(ACC_HIGH_RESET));

    // directed: never calibrated, degenerate range, clamping, window edges
    queue_frame(hot_frame(8'hFF, 512));
    s = '0;
    queue_frame(pack_frame(OP_CAL, s));
    queue_frame(hot_frame(8'hFF, 1023));
    s = {8{10'd500}};
    s[0] = 10'd600;
    s[1] = 10'd400;
    queue_frame(pack_frame(OP_CAL, s));
    queue_frame(hot_frame(8'hFF, 0));
    queue_frame(hot_frame(8'hFF, 1023));
    queue_frame(hot_frame(8'h01, 1023));
    queue_frame(hot_frame(8'h10, 1023));
    queue_frame(hot_frame(8'h80, 1023));
    queue_frame(hot_frame(8'hC0, 1023));
    queue_frame(hot_frame(8'h18, 550));
    queue_frame(hot_frame(8'h04, 1023));
    queue_frame(hot_frame(8'h20, 1023));
    queue_frame(hot_frame(8'h0C, 450));
    for (int k = 0; k < SENSOR_COUNT; k++) s[k] = SAMPLE_W'(380 + 40 * k);
    queue_frame(pack_frame(OP_RUN, s));

    // random phases, each under its own register setting
    for (int phase = 0; phase < 9; phase++) begin
      wait_drained();
      repeat (100) @(posedge clk);
      case (phase)
        0: apply_setting(0, 255, 128, 0, 65535, 2048, 0, 2048);
        1: apply_setting(200, 50, 255, 255, 0, 0, 2048, 0);
        2: apply_setting(255, 255, 0, 128, 1, 4095, 100, 1900);
        3: apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
        4: apply_setting(int'(PWM_MIN_RESET), int'(PWM_MAX_RESET), int'(BASE_DUTY_RESET),
                         int'(LEFT_CORR_RESET), int'(GAIN_KP_RESET), int'(TARGET_POS_RESET),
                         int'(ACC_LOW_RESET), int'(ACC_HIGH_RESET));
        default: begin
          mn = $urandom_range(0, 60);
          apply_setting(mn, mn + $urandom_range(0, 195), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 65535),
                        $urandom_range(0, 2048), $urandom_range(0, 1024),
                        $urandom_range(1024, 2048));
        end
      endcase
      // calibration band widens phase by phase
      band_lo = 450 - phase * 60;
      band_hi = 550 + phase * 60;
      if (band_lo < 0) band_lo = 0;
      if (band_hi > 1023) band_hi = 1023;
      repeat (130) queue_frame(random_frame(band_lo, band_hi));
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("results missing: %0d", expected_results.size());
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/lpsc_pkg.sv
rtl/core/lpsc_in_if.sv
rtl/core/lpsc_out_if.sv
rtl/core/line_position_steering_control.sv
test/line_position_steering_control_tb.sv
